// ----- src/clp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_pkg: shared types and constants for the competitive learning block
// Holds the transaction payload structs, request and register codes, and the
// control and link structs that run between the top level and the cells.
// ----------------------------------------------------------------------------
package clp_pkg;

  // Default sizes of the prototype array.
  localparam int CLP_MAX_CLUSTERS = 16;
  localparam int CLP_MAX_DIMS     = 16;

  // Fixed field widths that cover the whole parameter range.
  localparam int CLP_ADDR_W = 6;   // element address, up to 64 elements
  localparam int CLP_IDX_W  = 8;   // cluster index, up to 256 clusters
  localparam int CLP_NC_W   = 9;   // active cluster count, up to 256
  localparam int CLP_DIST_W = 39;  // accumulated squared distance
  localparam int CLP_VAL_W  = 15;  // Q1.14 element

  // Reported distance saturates at this value.
  localparam logic [CLP_DIST_W-1:0] CLP_DIST_MAX = CLP_DIST_W'(39'h1_FFFF_FFFF);

  // Register reset values.
  localparam logic [15:0] CLP_RATE_RST     = 16'd19661;
  localparam logic [4:0]  CLP_CLUSTERS_RST = 5'd4;
  localparam logic [4:0]  CLP_DIMS_RST     = 5'd12;

  // Request codes.
  localparam logic [1:0] REQ_LOAD     = 2'd0;
  localparam logic [1:0] REQ_TRAIN    = 2'd1;
  localparam logic [1:0] REQ_CLASSIFY = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RATE     = 2'd0;
  localparam logic [1:0] CFG_CLUSTERS = 2'd1;
  localparam logic [1:0] CFG_DIMS     = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  cluster_index;
    logic [3:0]  element_index;
    logic [14:0] element_value;
    logic        last_element;
  } clp_in_t;

  typedef struct packed {
    logic [3:0]  winner_index;
    logic [32:0] distance_sq;
    logic        was_updated;
  } clp_out_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic                  clr;
    logic                  sq_v;
    logic [CLP_ADDR_W-1:0] rd_addr;
    logic                  wr_en;
    logic [CLP_ADDR_W-1:0] wr_addr;
    logic [CLP_VAL_W-1:0]  wr_data;
    logic [CLP_NC_W-1:0]   active;
  } clp_ctrl_t;

  // Running best candidate handed from cell to cell.
  typedef struct packed {
    logic [CLP_IDX_W-1:0]  idx;
    logic [CLP_DIST_W-1:0] sum_sq;
  } clp_link_t;

endpackage

// ----- src/clp_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_cell: one prototype cell of the winner search chain
// Stores one prototype vector, accumulates its squared distance to the
// broadcast sample, and passes the better of its own and its neighbor's
// candidate down the chain every cycle.
// ----------------------------------------------------------------------------
module clp_cell import clp_pkg::*; #(
  parameter int MAX_DIMS = CLP_MAX_DIMS,
  parameter int CELL_ID  = 0
) (
  input  logic                 clk,
  input  clp_ctrl_t            ctrl_i,
  input  logic                 wr_sel_i,
  input  logic [CLP_VAL_W-1:0] s_i,
  input  clp_link_t            link_i,
  output clp_link_t            link_o,
  output logic [CLP_VAL_W-1:0] p_o
);

  localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  logic [CLP_VAL_W-1:0]   mem [MAX_DIMS];
  logic [CLP_VAL_W-1:0]   p_r;
  logic [2*CLP_VAL_W-1:0] sq_r;
  logic [2*CLP_VAL_W-1:0] sq_nxt;
  logic [CLP_DIST_W-1:0]  acc_r;
  clp_link_t              link_r;
  clp_link_t              link_nxt;
  logic [CLP_VAL_W-1:0]   adiff;
  logic                   take_own;

  // Prototype row: one write port, registered read.
  always_ff @(posedge clk) begin
    if (ctrl_i.wr_en && wr_sel_i) begin
      mem[ctrl_i.wr_addr[AW-1:0]] <= ctrl_i.wr_data;
    end
    p_r <= mem[ctrl_i.rd_addr[AW-1:0]];
  end

  // Squared element difference.
  always_comb begin
    adiff  = (s_i >= p_r) ? (s_i - p_r) : (p_r - s_i);
    sq_nxt = (2*CLP_VAL_W)'(adiff) * (2*CLP_VAL_W)'(adiff);
  end

  // Candidate selection; strict less keeps the lower index on ties.
  always_comb begin
    take_own = (CELL_ID == 0) ||
               ((CLP_NC_W'(CELL_ID) < ctrl_i.active) && (acc_r < link_i.sum_sq));
    if (take_own) begin
      link_nxt.idx    = CLP_IDX_W'(CELL_ID);
      link_nxt.sum_sq = acc_r;
    end else begin
      link_nxt = link_i;
    end
  end

  // Distance accumulator and chain register.
  always_ff @(posedge clk) begin
    sq_r   <= sq_nxt;
    link_r <= link_nxt;
    if (ctrl_i.clr) begin
      acc_r <= '0;
    end else if (ctrl_i.sq_v) begin
      acc_r <= acc_r + CLP_DIST_W'(sq_r);
    end
  end

  assign link_o = link_r;
  assign p_o    = p_r;

endmodule

// ----- src/competitive_learning_prototype_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// competitive_learning_prototype_update: winner-take-all prototype learning
// Keeps MAX_CLUSTERS prototype vectors in a chain of cells, finds the nearest
// prototype to a sample and, for training, moves the winner toward it.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions are taken when start is high and busy is low. Load,
//   and train or classify without the last flag, finish in the accept cycle
//   and leave busy low. A train or classify transaction with the last flag
//   raises busy while the block searches; out_data then holds the result,
//   marked by out_valid for exactly one cycle, as busy falls.
//   A search first accumulates distances over the D active dimensions (D =
//   active dimensions), one element per cycle from each cell's row memory,
//   then lets the best candidate ripple down the cell chain. Training then
//   updates the winner, one element per cycle through a single multiplier.
//   Configuration writes through cfg_we/cfg_index/cfg_wdata take effect at
//   once and must be made while busy is low.
//   Reset restores the register defaults and idles the sequencer; prototype
//   and sample contents are undefined until loaded. The receiver cannot stall.
// ----------------------------------------------------------------------------
module competitive_learning_prototype_update import clp_pkg::*; #(
  parameter int MAX_CLUSTERS = CLP_MAX_CLUSTERS,
  parameter int MAX_DIMS     = CLP_MAX_DIMS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  clp_in_t     in_data,
  output logic        out_valid,
  output clp_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int AW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CIW   = $clog2(MAX_CLUSTERS);
  localparam int CNT_W = $clog2(MAX_CLUSTERS + MAX_DIMS + 4) + 1;

  typedef enum logic [1:0] {S_IDLE, S_DIST, S_CHAIN, S_UPD} state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               train_r;
  logic [CIW-1:0]     win_r;
  logic               out_valid_r;
  clp_out_t           out_r;
  logic [15:0]        rate_r;
  logic [4:0]         clusters_r;
  logic [4:0]         dims_r;

  logic [CLP_VAL_W-1:0] sbuf [MAX_DIMS];
  logic [CLP_VAL_W-1:0] s_r;
  logic                 data_v_r;
  logic                 sq_v_r;
  logic                 t_v_r;
  logic [AW-1:0]        addr_d1_r;
  logic [AW-1:0]        addr_d2_r;
  logic signed [33:0]   t_r;
  logic [CLP_VAL_W-1:0] p_d_r;

  logic                 accept;
  logic                 ei_ok;
  logic                 ci_ok;
  logic                 search_go;
  logic [CNT_W-1:0]     nd_eff;
  logic [CLP_NC_W-1:0]  nc_eff;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  clp_ctrl_t            ctrl;
  logic [MAX_CLUSTERS-1:0] wr_sel;
  clp_link_t            links [MAX_CLUSTERS];
  clp_link_t            link_zero;
  logic [CLP_VAL_W-1:0] p_all [MAX_CLUSTERS];
  logic [CLP_VAL_W-1:0] p_sel;
  logic signed [16:0]   udiff;
  logic signed [33:0]   t_nxt;
  logic signed [33:0]   np;
  logic [CLP_DIST_W-1:0] best_dist;
  logic [32:0]          dist_sat;

  // Input decode.
  assign accept    = start && (state_r == S_IDLE);
  assign ei_ok     = (32'(in_data.element_index) < MAX_DIMS);
  assign ci_ok     = (32'(in_data.cluster_index) < MAX_CLUSTERS);
  assign search_go = accept && in_data.last_element &&
                     ((in_data.req_type == REQ_TRAIN) || (in_data.req_type == REQ_CLASSIFY));

  // Register values saturated into their legal ranges.
  always_comb begin
    if (dims_r == 5'd0) begin
      nd_eff = CNT_W'(1);
    end else if (32'(dims_r) > MAX_DIMS) begin
      nd_eff = CNT_W'(MAX_DIMS);
    end else begin
      nd_eff = CNT_W'(dims_r);
    end
    if (clusters_r == 5'd0) begin
      nc_eff = CLP_NC_W'(1);
    end else if (32'(clusters_r) > MAX_CLUSTERS) begin
      nc_eff = CLP_NC_W'(MAX_CLUSTERS);
    end else begin
      nc_eff = CLP_NC_W'(clusters_r);
    end
  end

  // Element read sweep for both the distance and the update phases.
  assign rd_en   = ((state_r == S_DIST) || (state_r == S_UPD)) && (cnt_r < nd_eff);
  assign rd_addr = cnt_r[AW-1:0];

  // Winner update arithmetic: p + floor((rate * (s - p) + 32768) / 65536).
  always_comb begin
    p_sel = p_all[win_r];
    udiff = $signed({2'b00, s_r}) - $signed({2'b00, p_sel});
    t_nxt = ($signed({1'b0, rate_r}) * udiff) + 34'sd32768;
    np    = $signed({19'd0, p_d_r}) + (t_r >>> 16);
  end

  // Cell write port: loads while idle, winner updates during training.
  always_comb begin
    ctrl.clr     = search_go;
    ctrl.sq_v    = sq_v_r;
    ctrl.rd_addr = CLP_ADDR_W'(rd_addr);
    ctrl.active  = nc_eff;
    wr_sel       = '0;
    if (t_v_r) begin
      ctrl.wr_en   = 1'b1;
      ctrl.wr_addr = CLP_ADDR_W'(addr_d2_r);
      ctrl.wr_data = np[CLP_VAL_W-1:0];
      wr_sel[win_r] = 1'b1;
    end else begin
      ctrl.wr_en   = accept && (in_data.req_type == REQ_LOAD) && ci_ok && ei_ok;
      ctrl.wr_addr = CLP_ADDR_W'(in_data.element_index);
      ctrl.wr_data = in_data.element_value;
      wr_sel[CIW'(in_data.cluster_index)] = 1'b1;
    end
  end

  // Chain of prototype cells.
  assign link_zero = '0;
  for (genvar c = 0; c < MAX_CLUSTERS; c++) begin : g_cell
    clp_cell #(
      .MAX_DIMS (MAX_DIMS),
      .CELL_ID  (c)
    ) u_cell (
      .clk      (clk),
      .ctrl_i   (ctrl),
      .wr_sel_i (wr_sel[c]),
      .s_i      (s_r),
      .link_i   ((c == 0) ? link_zero : links[(c == 0) ? 0 : c - 1]),
      .link_o   (links[c]),
      .p_o      (p_all[c])
    );
  end

  // Distance of the chain's final candidate, saturated to the output width.
  assign best_dist = links[MAX_CLUSTERS-1].sum_sq;
  assign dist_sat  = (best_dist > CLP_DIST_MAX) ? 33'h1_FFFF_FFFF : best_dist[32:0];

  // Sample buffer and datapath pipeline.
  always_ff @(posedge clk) begin
    if (accept && ei_ok &&
        ((in_data.req_type == REQ_TRAIN) || (in_data.req_type == REQ_CLASSIFY))) begin
      sbuf[AW'(in_data.element_index)] <= in_data.element_value;
    end
    s_r       <= sbuf[rd_addr];
    addr_d1_r <= rd_addr;
    addr_d2_r <= addr_d1_r;
    t_r       <= t_nxt;
    p_d_r     <= p_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_v_r <= 1'b0;
      sq_v_r   <= 1'b0;
      t_v_r    <= 1'b0;
    end else begin
      data_v_r <= rd_en;
      sq_v_r   <= data_v_r && (state_r == S_DIST);
      t_v_r    <= data_v_r && (state_r == S_UPD);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r     <= CLP_RATE_RST;
      clusters_r <= CLP_CLUSTERS_RST;
      dims_r     <= CLP_DIMS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RATE:     rate_r     <= cfg_wdata;
        CFG_CLUSTERS: clusters_r <= cfg_wdata[4:0];
        CFG_DIMS:     dims_r     <= cfg_wdata[4:0];
        default:      ;
      endcase
    end
  end

  // Sequencer with registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      train_r     <= 1'b0;
      win_r       <= '0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (search_go) begin
            state_r <= S_DIST;
            cnt_r   <= '0;
            train_r <= (in_data.req_type == REQ_TRAIN);
          end
        end
        S_DIST: begin
          if (cnt_r == nd_eff + CNT_W'(1)) begin
            state_r <= S_CHAIN;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_CHAIN: begin
          if (cnt_r == CNT_W'(MAX_CLUSTERS)) begin
            win_r                <= links[MAX_CLUSTERS-1].idx[CIW-1:0];
            out_r.winner_index   <= 4'(links[MAX_CLUSTERS-1].idx[CIW-1:0]);
            out_r.distance_sq    <= dist_sat;
            out_r.was_updated    <= train_r;
            cnt_r                <= '0;
            if (train_r) begin
              state_r <= S_UPD;
            end else begin
              state_r     <= S_IDLE;
              out_valid_r <= 1'b1;
            end
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_UPD: begin
          if (cnt_r == nd_eff + CNT_W'(1)) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  // A result is delivered only as the block returns to idle.
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  // Busy rises only after an accepted start.
  a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start)) else $error("busy without start");

  // One result transaction per search.
  a_single_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("repeated result strobe");
`endif

endmodule
